// ===== rtl/core/tvc_pkg.sv =====
// Shared types and constants for the tone vote classifier.
package tvc_pkg;

  localparam int TONES      = 14;
  localparam int SLOTS      = 5;
  localparam int FREQ_W     = 16;
  localparam int VOTE_W     = 8;
  localparam int TONE_W     = 4;
  localparam int SLOT_W     = 3;
  localparam int KIND_W     = 2;
  localparam int LIMIT_W    = 15;
  localparam int WIN_W      = 5;
  localparam int HIT_W      = $clog2(SLOTS + 1);
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [FREQ_W-1:0]  EMPTY_ENTRY = 16'hFFFF;
  localparam logic [FREQ_W-1:0]  SILENCE_FREQ = 16'hFFFF;
  localparam logic [VOTE_W-1:0]  VOTE_MAX    = 8'hFF;
  localparam logic [LIMIT_W-1:0] LOW_RST     = 15'd1;
  localparam logic [LIMIT_W-1:0] HIGH_RST    = 15'd30000;
  localparam logic [WIN_W-1:0]   WIN_RST     = 5'd5;

  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_WIN  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_VOTE,
    OP_DECIDE,
    OP_SILENCE
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TONE    = 2'd0,
    KIND_NONE    = 2'd1,
    KIND_SILENCE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] low_limit;
    logic [LIMIT_W-1:0] high_limit;
    logic [WIN_W-1:0]   window_len;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [TONE_W-1:0]  tone_sel;
    logic [SLOT_W-1:0]  slot_sel;
    logic [FREQ_W-1:0]  freq;
    logic [TONE_W-1:0]  best_tone;
    logic [VOTE_W-1:0]  best_score;
  } flit_t;

  typedef struct packed {
    kind_t             kind;
    logic [TONE_W-1:0] tone;
    logic [VOTE_W-1:0] score;
  } res_t;

endpackage

// ===== rtl/core/tvc_head.sv =====
// Entry stage: range check, report counting and window decision.
module tvc_head (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic                       action,
  input  logic [tvc_pkg::TONE_W-1:0] tone_sel,
  input  logic [tvc_pkg::SLOT_W-1:0] slot_sel,
  input  logic [tvc_pkg::FREQ_W-1:0] entry_freq,
  input  logic [tvc_pkg::FREQ_W-1:0] peak_freq,
  input  tvc_pkg::cfg_t              cfg,
  output tvc_pkg::flit_t             flit_o
);

  logic [tvc_pkg::WIN_W-1:0] cnt_r, cnt_nxt;
  logic [tvc_pkg::WIN_W:0]   cnt_inc, limit;
  logic                      in_range, decide, keep;
  tvc_pkg::op_t              op;
  tvc_pkg::flit_t            flit_r, flit_nxt;

  always_comb begin
    in_range = !peak_freq[tvc_pkg::FREQ_W-1]
            && (peak_freq[tvc_pkg::LIMIT_W-1:0] >= cfg.low_limit)
            && (peak_freq[tvc_pkg::LIMIT_W-1:0] <= cfg.high_limit);
    cnt_inc  = {1'b0, cnt_r} + (tvc_pkg::WIN_W+1)'(1);
    limit    = (cfg.window_len == '0) ? (tvc_pkg::WIN_W+1)'(32) : {1'b0, cfg.window_len};
    decide   = cnt_inc >= limit;
    cnt_nxt  = cnt_r;
    keep     = 1'b0;
    op       = tvc_pkg::OP_LOAD;
    priority if (!action) begin
      keep = 1'b1;
    end else if (peak_freq == tvc_pkg::SILENCE_FREQ) begin
      op      = tvc_pkg::OP_SILENCE;
      keep    = cnt_r != '0;
      cnt_nxt = '0;
    end else if (in_range) begin
      keep    = 1'b1;
      op      = decide ? tvc_pkg::OP_DECIDE : tvc_pkg::OP_VOTE;
      cnt_nxt = decide ? '0 : cnt_inc[tvc_pkg::WIN_W-1:0];
    end else begin
      keep = 1'b0;
    end

    flit_nxt            = flit_r;
    flit_nxt.valid      = in_valid && keep;
    flit_nxt.op         = op;
    flit_nxt.tone_sel   = tone_sel;
    flit_nxt.slot_sel   = slot_sel;
    flit_nxt.freq       = action ? peak_freq : entry_freq;
    flit_nxt.best_tone  = '0;
    flit_nxt.best_score = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      flit_r.valid <= 1'b0;
    end else if (en) begin
      flit_r <= flit_nxt;
      if (in_valid) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign flit_o = flit_r;

endmodule

// ===== rtl/core/tvc_cell.sv =====
// One tone cell: signature row, vote counter and running best-tone stage.
module tvc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [tvc_pkg::TONE_W-1:0] cell_idx,
  input  tvc_pkg::flit_t             flit_i,
  output tvc_pkg::flit_t             flit_o
);

  logic [tvc_pkg::FREQ_W-1:0] row_r [tvc_pkg::SLOTS];
  logic [tvc_pkg::VOTE_W-1:0] votes_r, votes_upd;
  logic [tvc_pkg::HIT_W-1:0]  hits;
  logic [tvc_pkg::VOTE_W:0]   sum;
  tvc_pkg::flit_t             flit_r, flit_nxt;

  always_comb begin
    hits = '0;
    for (int s = 0; s < tvc_pkg::SLOTS; s++) begin
      if (row_r[s] == flit_i.freq) begin
        hits = hits + tvc_pkg::HIT_W'(1);
      end
    end
    sum       = {1'b0, votes_r} + (tvc_pkg::VOTE_W+1)'(hits);
    votes_upd = sum[tvc_pkg::VOTE_W] ? tvc_pkg::VOTE_MAX : sum[tvc_pkg::VOTE_W-1:0];

    flit_nxt = flit_i;
    if (flit_i.op == tvc_pkg::OP_DECIDE && votes_upd > flit_i.best_score) begin
      flit_nxt.best_tone  = cell_idx;
      flit_nxt.best_score = votes_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      votes_r      <= '0;
      flit_r.valid <= 1'b0;
      for (int s = 0; s < tvc_pkg::SLOTS; s++) begin
        row_r[s] <= tvc_pkg::EMPTY_ENTRY;
      end
    end else if (en) begin
      flit_r <= flit_nxt;
      if (flit_i.valid) begin
        unique case (flit_i.op)
          tvc_pkg::OP_LOAD: begin
            if (flit_i.tone_sel == cell_idx) begin
              for (int s = 0; s < tvc_pkg::SLOTS; s++) begin
                if (flit_i.slot_sel == tvc_pkg::SLOT_W'(s)) begin
                  row_r[s] <= flit_i.freq;
                end
              end
            end
          end
          tvc_pkg::OP_VOTE:    votes_r <= votes_upd;
          tvc_pkg::OP_DECIDE:  votes_r <= '0;
          tvc_pkg::OP_SILENCE: votes_r <= votes_r;
        endcase
      end
    end
  end

  assign flit_o = flit_r;

endmodule

// ===== rtl/core/tvc_outq.sv =====
// Two-entry result queue at the tail of the cell chain.
module tvc_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tvc_pkg::flit_t             tail,
  output logic                       room,
  input  logic                       out_ready,
  output logic                       out_valid,
  output tvc_pkg::res_t              out_res
);

  tvc_pkg::res_t res_r [2];
  tvc_pkg::res_t push_res;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr_ptr_r, rd_ptr_r;
  logic          push, pop;

  always_comb begin
    room      = cnt_r != 2'd2;
    out_valid = cnt_r != 2'd0;
    push      = room && tail.valid
             && (tail.op == tvc_pkg::OP_DECIDE || tail.op == tvc_pkg::OP_SILENCE);
    pop       = out_valid && out_ready;
    cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

    push_res = '{kind: tvc_pkg::KIND_SILENCE, tone: '0, score: '0};
    if (tail.op == tvc_pkg::OP_DECIDE) begin
      if (tail.best_score == '0) begin
        push_res.kind = tvc_pkg::KIND_NONE;
      end else begin
        push_res.kind  = tvc_pkg::KIND_TONE;
        push_res.tone  = tail.best_tone;
        push_res.score = tail.best_score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        res_r[wr_ptr_r] <= push_res;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  assign out_res = res_r[rd_ptr_r];

endmodule

// ===== rtl/core/tone_vote_classifier.sv =====
// Tone vote classifier top level: register bank, entry stage, tone cell chain, result queue.
// A result transaction passes the entry stage register, every tone cell and the result queue.
// Throughput: one transaction per cycle unless stalled; each item steps one cell per cycle.
// in_tready drops only while the two-entry result queue is full; the whole chain then holds.
// Reset (rst_n low, synchronous): signature table empty, votes and report count zero,
// limits 1 and 30000, window 5, queue empty.
module tone_vote_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tone_sel[3:0], slot_sel[6:4], entry_freq[22:7], peak_freq[38:23], zero[39]
  input  logic [tvc_pkg::IN_DATA_W-1:0]     in_tdata,
  // action[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tone[3:0], score[11:4], zero[15:12]
  output logic [tvc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // kind[1:0]
  output logic [tvc_pkg::KIND_W-1:0]        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tvc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tvc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tvc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  tvc_pkg::cfg_t  cfg_r;
  tvc_pkg::flit_t chain [tvc_pkg::TONES+1];
  tvc_pkg::res_t  res;
  logic           adv, cfg_wr;
  logic [1:0]     reg_idx;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit  <= tvc_pkg::LOW_RST;
      cfg_r.high_limit <= tvc_pkg::HIGH_RST;
      cfg_r.window_len <= tvc_pkg::WIN_RST;
    end else if (cfg_wr) begin
      priority case (reg_idx)
        tvc_pkg::REG_LOW:  cfg_r.low_limit  <= cfg_pwdata[tvc_pkg::LIMIT_W-1:0];
        tvc_pkg::REG_HIGH: cfg_r.high_limit <= cfg_pwdata[tvc_pkg::LIMIT_W-1:0];
        tvc_pkg::REG_WIN:  cfg_r.window_len <= cfg_pwdata[tvc_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (reg_idx)
      tvc_pkg::REG_LOW:  cfg_prdata = tvc_pkg::CFG_DATA_W'(cfg_r.low_limit);
      tvc_pkg::REG_HIGH: cfg_prdata = tvc_pkg::CFG_DATA_W'(cfg_r.high_limit);
      tvc_pkg::REG_WIN:  cfg_prdata = tvc_pkg::CFG_DATA_W'(cfg_r.window_len);
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_tready = adv;

  tvc_head u_head (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (in_tvalid),
    .action     (in_tuser),
    .tone_sel   (in_tdata[3:0]),
    .slot_sel   (in_tdata[6:4]),
    .entry_freq (in_tdata[22:7]),
    .peak_freq  (in_tdata[38:23]),
    .cfg        (cfg_r),
    .flit_o     (chain[0])
  );

  for (genvar t = 0; t < tvc_pkg::TONES; t++) begin : g_cell
    tvc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .cell_idx (tvc_pkg::TONE_W'(t)),
      .flit_i   (chain[t]),
      .flit_o   (chain[t+1])
    );
  end

  tvc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail      (chain[tvc_pkg::TONES]),
    .room      (adv),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {4'd0, res.score, res.tone};

endmodule

// ===== rtl/core/tvc_checker.sv =====
// Port-level checks for the tone vote classifier, bound to the top level.
module tvc_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tvc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [tvc_pkg::KIND_W-1:0]     out_tuser
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result transaction straight after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == tvc_pkg::KIND_TONE || out_tuser == tvc_pkg::KIND_NONE
                    || out_tuser == tvc_pkg::KIND_SILENCE))
    else $error("undefined result kind");

  a_no_tone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != tvc_pkg::KIND_TONE |-> out_tdata == '0)
    else $error("tone or score set without a recognised tone");

  a_tone_scored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tvc_pkg::KIND_TONE |-> out_tdata[11:4] != '0)
    else $error("recognised tone with zero score");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transaction changed");

endmodule

bind tone_vote_classifier tvc_props u_tvc_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
